// ===== rtl/core/bltl_pkg.sv =====
// shared constants and types for the bilinear table lookup
`default_nettype none
package bltl_pkg;

   // field widths
   localparam int DATA_W      = 24;
   localparam int ROW_COUNT_W = 5;
   localparam int COL_COUNT_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int WEIGHT_W    = 17;
   localparam int SPAN_W      = 25;

   // default sizes
   localparam int MAX_ROWS_DEF   = 16;
   localparam int MAX_COLS_DEF   = 8;
   localparam int NUM_TABLES_DEF = 3;

   // unit weight in q1.16
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // item modes
   typedef enum logic [1:0] {
      MODE_ROW_BP = 2'd0,
      MODE_COL_BP = 2'd1,
      MODE_GRID   = 2'd2,
      MODE_LOOKUP = 2'd3
   } mode_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

// ===== rtl/core/bltl_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module bltl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/bltl_div.sv =====
// radix-2 restoring divider for the q1.16 axis weight, one bit per cycle
`default_nettype none
module bltl_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [bltl_pkg::SPAN_W-1:0]       dividend,
   input  wire logic [bltl_pkg::SPAN_W-1:0]       divisor,
   output logic                                   done,
   output logic      [bltl_pkg::WEIGHT_W-1:0]     quotient
);

   localparam int REM_W = bltl_pkg::SPAN_W + 1;
   localparam int CNT_W = $clog2(bltl_pkg::WEIGHT_W + 1);

   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [bltl_pkg::SPAN_W-1:0]   dsr_ff, dsr_in;
   logic [bltl_pkg::WEIGHT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [REM_W-1:0]              trial;
   logic                          bit_ok;

   // one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = rem_ff - {1'b0, dsr_ff};
      bit_ok  = (rem_ff >= {1'b0, dsr_ff});
      if (start) begin
         rem_in = {1'b0, dividend};
         dsr_in = divisor;
         q_in   = '0;
         cnt_in = CNT_W'(bltl_pkg::WEIGHT_W);
      end else if (cnt_ff != '0) begin
         rem_in = bit_ok ? {trial[REM_W-2:0], 1'b0} : {rem_ff[REM_W-2:0], 1'b0};
         q_in   = {q_ff[bltl_pkg::WEIGHT_W-2:0], bit_ok};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   // done is a single pulse after a full count
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");

   a_done_after_count: assert property (@(posedge clock) disable iff (reset)
      done_in |-> (cnt_ff == CNT_W'(1)) && !start)
      else $error("divider done without final step");

endmodule
`default_nettype wire

// ===== rtl/core/bilinear_table_lookup.sv =====
// top level of the bilinear table lookup: search, weight division and corner blend
//
// channel   direction  handshake                 payload
// req       in         start & !busy             mode, table, indexes, value, queries
// rsp       out        rsp_strobe, one cycle     interpolated
// csr       in         csr_valid & csr_ready     csr_index, csr_data
//
// load words leave busy low; the ram is written at the accept edge.
// a lookup holds busy while it searches each axis: it checks the first breakpoint,
// then the last, else scans up from the second breakpoint and, when the weight needs
// it, runs the bit-serial divider; then come the four corner reads through the single
// grid ram port, the multiply-accumulate and the result.
// a lookup with a table out of range answers 0 in the cycle after accept.
// synchronous reset sets both counts to 2; the rams are not cleared.
// the receiver cannot stall: the result strobe lasts one cycle.
`default_nettype none
module bilinear_table_lookup #(
   parameter int MAX_ROWS   = bltl_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = bltl_pkg::MAX_COLS_DEF,
   parameter int NUM_TABLES = bltl_pkg::NUM_TABLES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [1:0]                           req_table_select,
   input  wire logic [3:0]                           req_row_index,
   input  wire logic [2:0]                           req_col_index,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_load_value,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_row_query,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_col_query,
   output logic                                      rsp_strobe,
   output logic signed [bltl_pkg::DATA_W-1:0]        rsp_interpolated,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bltl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bltl_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DW    = bltl_pkg::DATA_W;
   localparam int WW    = bltl_pkg::WEIGHT_W;
   localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int GD    = NUM_TABLES * MAX_ROWS * MAX_COLS;
   localparam int GA    = $clog2(GD);
   localparam int AXMAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int PW    = $clog2(AXMAX);
   localparam int CW    = $clog2(AXMAX + 1);
   localparam int TW    = 2;
   localparam int WPW   = 2 * WW - 1;
   localparam int ACW   = 58;
   localparam int RSW   = ACW - 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AX_FIRST,
      ST_AX_LAST,
      ST_AX_SCAN,
      ST_AX_DIV,
      ST_GR_ADDR,
      ST_GR_MUL,
      ST_GR_ACC,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [bltl_pkg::ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [bltl_pkg::COL_COUNT_W-1:0] col_count_ff, col_count_in;
   logic signed [DW-1:0]         rq_ff, rq_in, cq_ff, cq_in, lo_ff, lo_in;
   logic [TW-1:0]                tsel_ff, tsel_in;
   logic                         axis_ff, axis_in;
   logic [PW-1:0]                ptr_ff, ptr_in;
   logic [RA-1:0]                ri_ff, ri_in;
   logic [CA-1:0]                ci_ff, ci_in;
   logic [WW-1:0]                wr_ff, wr_in, wc_ff, wc_in;
   logic [1:0]                   k_ff, k_in;
   logic [WPW-1:0]               wp_ff, wp_in;
   logic signed [ACW-1:0]        prod_ff, prod_in, acc_ff, acc_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic signed [DW-1:0]         rsp_val_ff, rsp_val_in;

   logic                         accept, row_we, col_we, grid_we;
   bltl_pkg::mode_type           mode;
   logic [DW-1:0]                row_rd, col_rd, grid_rd;
   logic [GA-1:0]                grid_waddr, grid_raddr;
   logic [CW-1:0]                n_row, n_col, n_ax;
   logic signed [DW-1:0]         bp, xq;
   logic signed [bltl_pkg::SPAN_W-1:0] span, off;
   logic                         div_start, div_done;
   logic [WW-1:0]                div_q;
   logic                         ax_done;
   logic [PW-1:0]                ax_idx;
   logic [WW-1:0]                ax_w;
   logic [WW-1:0]                fr, fc;
   logic signed [RSW-1:0]        res;

   assign mode   = bltl_pkg::mode_type'(req_mode);
   assign accept = start && !busy;

   // load word writes, dropped when out of range
   assign row_we  = accept && (mode == bltl_pkg::MODE_ROW_BP) && (int'(req_row_index) < MAX_ROWS);
   assign col_we  = accept && (mode == bltl_pkg::MODE_COL_BP) && (int'(req_col_index) < MAX_COLS);
   assign grid_we = accept && (mode == bltl_pkg::MODE_GRID) &&
                    (int'(req_table_select) < NUM_TABLES) &&
                    (int'(req_row_index) < MAX_ROWS) && (int'(req_col_index) < MAX_COLS);
   assign grid_waddr = GA'(int'(req_table_select) * MAX_ROWS * MAX_COLS +
                           int'(req_row_index) * MAX_COLS + int'(req_col_index));

   // corner address: k[0] steps the row, k[1] the column
   assign grid_raddr = GA'(int'(tsel_ff) * MAX_ROWS * MAX_COLS +
                           (int'(ri_ff) + int'(k_ff[0])) * MAX_COLS +
                           int'(ci_ff) + int'(k_ff[1]));

   bltl_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (RA'(req_row_index)),
      .wdata (req_load_value),
      .raddr (RA'(ptr_in)),
      .rdata (row_rd)
   );

   bltl_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_col_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (CA'(req_col_index)),
      .wdata (req_load_value),
      .raddr (CA'(ptr_in)),
      .rdata (col_rd)
   );

   bltl_ram #(.WIDTH(DW), .DEPTH(GD)) u_grid_ram (
      .clock (clock),
      .we    (grid_we),
      .waddr (grid_waddr),
      .wdata (req_load_value),
      .raddr (grid_raddr),
      .rdata (grid_rd)
   );

   bltl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_q)
   );

   // clamped counts
   assign n_row = (row_count_ff < 2) ? CW'(2) :
                  (int'(row_count_ff) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(row_count_ff);
   assign n_col = (col_count_ff < 2) ? CW'(2) :
                  (int'(col_count_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count_ff);
   assign n_ax  = axis_ff ? n_col : n_row;
   assign bp    = axis_ff ? $signed(col_rd) : $signed(row_rd);
   assign xq    = axis_ff ? cq_ff : rq_ff;
   assign span  = {bp[DW-1], bp} - {lo_ff[DW-1], lo_ff};
   assign off   = {xq[DW-1], xq} - {lo_ff[DW-1], lo_ff};
   assign fr    = k_ff[0] ? wr_ff : bltl_pkg::WEIGHT_ONE - wr_ff;
   assign fc    = k_ff[1] ? wc_ff : bltl_pkg::WEIGHT_ONE - wc_ff;
   assign res   = RSW'(acc_ff >>> 32);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      rq_in         = rq_ff;
      cq_in         = cq_ff;
      lo_in         = lo_ff;
      tsel_in       = tsel_ff;
      axis_in       = axis_ff;
      ptr_in        = ptr_ff;
      ri_in         = ri_ff;
      ci_in         = ci_ff;
      wr_in         = wr_ff;
      wc_in         = wc_ff;
      k_in          = k_ff;
      wp_in         = wp_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_val_in    = rsp_val_ff;
      div_start     = 1'b0;
      ax_done       = 1'b0;
      ax_idx        = '0;
      ax_w          = '0;

      // register writes
      if (csr_valid) begin
         case (bltl_pkg::csr_index_type'(csr_index))
            bltl_pkg::CSR_ROW_COUNT: row_count_in = csr_data[bltl_pkg::ROW_COUNT_W-1:0];
            bltl_pkg::CSR_COL_COUNT: col_count_in = csr_data[bltl_pkg::COL_COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            ptr_in = '0;
            if (accept && (mode == bltl_pkg::MODE_LOOKUP)) begin
               if (int'(req_table_select) < NUM_TABLES) begin
                  rq_in    = req_row_query;
                  cq_in    = req_col_query;
                  tsel_in  = req_table_select;
                  axis_in  = 1'b0;
                  acc_in   = '0;
                  state_in = ST_AX_FIRST;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_val_in    = '0;
               end
            end
         end
         // first breakpoint
         ST_AX_FIRST: begin
            lo_in = bp;
            if (xq <= bp) begin
               ax_done = 1'b1;
            end else begin
               ptr_in   = PW'(n_ax - 1'b1);
               state_in = ST_AX_LAST;
            end
         end
         // last breakpoint
         ST_AX_LAST: begin
            if (xq >= bp) begin
               ax_done = 1'b1;
               ax_idx  = PW'(n_ax - 2'd2);
               ax_w    = bltl_pkg::WEIGHT_ONE;
            end else begin
               ptr_in   = PW'(1);
               state_in = ST_AX_SCAN;
            end
         end
         // walk up to the first breakpoint not below the query
         ST_AX_SCAN: begin
            if ((bp >= xq) || (ptr_ff == PW'(n_ax - 1'b1))) begin
               ptr_in = ptr_ff - 1'b1;
               if (span[bltl_pkg::SPAN_W-1] || (span == '0) ||
                   off[bltl_pkg::SPAN_W-1] || (off == '0)) begin
                  ax_done = 1'b1;
                  ax_idx  = ptr_ff - 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_AX_DIV;
               end
            end else begin
               lo_in  = bp;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_AX_DIV: begin
            if (div_done) begin
               ax_done = 1'b1;
               ax_idx  = ptr_ff;
               ax_w    = div_q;
            end
         end
         // corner address issue and weight product
         ST_GR_ADDR: begin
            wp_in    = WPW'(fr * fc);
            state_in = ST_GR_MUL;
         end
         ST_GR_MUL: begin
            prod_in  = ACW'($signed(grid_rd) * $signed({1'b0, wp_ff}));
            state_in = ST_GR_ACC;
         end
         ST_GR_ACC: begin
            acc_in = acc_ff + prod_ff;
            k_in   = k_ff + 1'b1;
            state_in = (k_ff == 2'd3) ? ST_FINISH : ST_GR_ADDR;
         end
         // floor, saturate and strobe
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (res > RSW'(2 ** (DW - 1) - 1)) begin
               rsp_val_in = {1'b0, {(DW-1){1'b1}}};
            end else if (res < -RSW'(2 ** (DW - 1))) begin
               rsp_val_in = {1'b1, {(DW-1){1'b0}}};
            end else begin
               rsp_val_in = DW'(res);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // axis finished: move to column axis or to the blend
      if (ax_done) begin
         ptr_in = '0;
         if (!axis_ff) begin
            ri_in    = RA'(ax_idx);
            wr_in    = ax_w;
            axis_in  = 1'b1;
            state_in = ST_AX_FIRST;
         end else begin
            ci_in    = CA'(ax_idx);
            wc_in    = ax_w;
            k_in     = '0;
            state_in = ST_GR_ADDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      rq_in_hold: begin
         rq_ff      <= rq_in;
         cq_ff      <= cq_in;
         lo_ff      <= lo_in;
         tsel_ff    <= tsel_in;
         ri_ff      <= ri_in;
         ci_ff      <= ci_in;
         wr_ff      <= wr_in;
         wc_ff      <= wc_in;
         wp_ff      <= wp_in;
         prod_ff    <= prod_in;
         acc_ff     <= acc_in;
         rsp_val_ff <= rsp_val_in;
         axis_ff    <= axis_in;
         k_ff       <= k_in;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         row_count_ff  <= bltl_pkg::ROW_COUNT_W'(2);
         col_count_ff  <= bltl_pkg::COL_COUNT_W'(2);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_interpolated = rsp_val_ff;
   assign csr_ready        = 1'b1;

   // a result never shows while a lookup is in flight
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a lookup on a missing table answers zero and never goes busy
   a_bad_table: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == bltl_pkg::MODE_LOOKUP) && (int'(req_table_select) >= NUM_TABLES)
      |=> rsp_strobe && (rsp_interpolated == '0) && !busy)
      else $error("bad table lookup not answered");

   // load words never occupy the engine
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      accept && (mode != bltl_pkg::MODE_LOOKUP) |=> !busy && !rsp_strobe)
      else $error("load word started work");

   // the divider only finishes while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_AX_DIV))
      else $error("divider result lost");

endmodule
`default_nettype wire

// ===== test/bltl_lookup_checker.sv =====
// checker for the bilinear table lookup: tracks tables, predicts and compares results
`default_nettype none
module bltl_lookup_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [1:0]                           req_table_select,
   input  wire logic [3:0]                           req_row_index,
   input  wire logic [2:0]                           req_col_index,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_load_value,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_row_query,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   req_col_query,
   input  wire logic                                 rsp_strobe,
   input  wire logic signed [bltl_pkg::DATA_W-1:0]   rsp_interpolated,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [bltl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bltl_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                        fail_count,
   output int                                        pending
);

   localparam int DW = bltl_pkg::DATA_W;
   localparam int NR = bltl_pkg::MAX_ROWS_DEF;
   localparam int NC = bltl_pkg::MAX_COLS_DEF;
   localparam int NT = bltl_pkg::NUM_TABLES_DEF;

   // shadow copy of the tables and counts
   logic signed [DW-1:0]                row_bp [NR];
   logic signed [DW-1:0]                col_bp [NR];
   logic signed [DW-1:0]                grid [NT][NR][NC];
   logic [bltl_pkg::ROW_COUNT_W-1:0]    row_cnt;
   logic [bltl_pkg::COL_COUNT_W-1:0]    col_cnt;
   logic signed [DW-1:0]                expected_interp [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // interval and q1.16 weight on one axis
   function automatic void locate_axis(input logic signed [DW-1:0] bp [NR], input int n,
                                       input logic signed [DW-1:0] x,
                                       output int idx, output longint wt);
      int     j;
      longint span, off, q;
      if (x <= bp[0]) begin
         idx = 0;
         wt  = 0;
      end else if (x >= bp[n-1]) begin
         idx = n - 2;
         wt  = 65536;
      end else begin
         j = 1;
         while (j < n - 1 && bp[j] < x) j++;
         idx  = j - 1;
         span = longint'(bp[j]) - longint'(bp[j-1]);
         off  = longint'(x) - longint'(bp[j-1]);
         if (span <= 0 || off <= 0) wt = 0;
         else begin
            q  = (off <<< 16) / span;
            wt = (q > 65536) ? 65536 : q;
         end
      end
   endfunction

   // bilinear blend of the four corners, floored and saturated
   function automatic logic signed [DW-1:0] blend_lookup(input int tsel,
                                                         input logic signed [DW-1:0] rq,
                                                         input logic signed [DW-1:0] cq);
      int     nr, nc, ri, ci;
      longint wr, wc, sum, res;
      nr = (row_cnt < 2) ? 2 : (int'(row_cnt) > NR) ? NR : int'(row_cnt);
      nc = (col_cnt < 2) ? 2 : (int'(col_cnt) > NC) ? NC : int'(col_cnt);
      locate_axis(row_bp, nr, rq, ri, wr);
      locate_axis(col_bp, nc, cq, ci, wc);
      sum = longint'(grid[tsel][ri][ci])     * ((65536 - wr) * (65536 - wc))
          + longint'(grid[tsel][ri+1][ci])   * (wr * (65536 - wc))
          + longint'(grid[tsel][ri][ci+1])   * ((65536 - wr) * wc)
          + longint'(grid[tsel][ri+1][ci+1]) * (wr * wc);
      res = sum >>> 32;
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      return res[DW-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         row_cnt <= bltl_pkg::ROW_COUNT_W'(2);
         col_cnt <= bltl_pkg::COL_COUNT_W'(2);
         expected_interp.delete();
      end else begin
         // results are compared before new words are queued
         if (rsp_strobe) begin
            if (expected_interp.size() == 0)
               report_mismatch($sformatf("unexpected result %0d", rsp_interpolated));
            else if (rsp_interpolated !== expected_interp[0]) begin
               report_mismatch($sformatf("interpolated %0d, predicted %0d",
                                         rsp_interpolated, expected_interp[0]));
               void'(expected_interp.pop_front());
            end else
               void'(expected_interp.pop_front());
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == bltl_pkg::CSR_ROW_COUNT)
               row_cnt <= csr_data[bltl_pkg::ROW_COUNT_W-1:0];
            else if (csr_index == bltl_pkg::CSR_COL_COUNT)
               col_cnt <= csr_data[bltl_pkg::COL_COUNT_W-1:0];
         end
         // accepted request word
         if (start && !busy) begin
            case (bltl_pkg::mode_type'(req_mode))
               bltl_pkg::MODE_ROW_BP: row_bp[req_row_index] = req_load_value;
               bltl_pkg::MODE_COL_BP: col_bp[req_col_index] = req_load_value;
               bltl_pkg::MODE_GRID: begin
                  if (int'(req_table_select) < NT)
                     grid[req_table_select][req_row_index][req_col_index] = req_load_value;
               end
               bltl_pkg::MODE_LOOKUP: begin
                  if (int'(req_table_select) >= NT) expected_interp.push_back('0);
                  else expected_interp.push_back(blend_lookup(int'(req_table_select),
                                                              req_row_query, req_col_query));
               end
               default: ;
            endcase
         end
      end
      pending <= expected_interp.size();
   end

endmodule
`default_nettype wire

// ===== test/tb_bilinear_table_lookup.sv =====
// testbench top for the bilinear table lookup: stimulus, clock, reset and verdict
`default_nettype none
module tb_bilinear_table_lookup;

   localparam int DW = bltl_pkg::DATA_W;
   localparam int NT = bltl_pkg::NUM_TABLES_DEF;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [1:0]                          req_mode = '0;
   logic [1:0]                          req_table_select = '0;
   logic [3:0]                          req_row_index = '0;
   logic [2:0]                          req_col_index = '0;
   logic signed [DW-1:0]                req_load_value = '0;
   logic signed [DW-1:0]                req_row_query = '0;
   logic signed [DW-1:0]                req_col_query = '0;
   logic                                rsp_strobe;
   logic signed [DW-1:0]                rsp_interpolated;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bltl_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [bltl_pkg::CSR_DATA_W-1:0]     csr_data = '0;
   int                                  fail_count;
   int                                  pending;

   // tb copy of breakpoints, used only to aim queries
   logic signed [DW-1:0]     row_bp_seen [16];
   logic signed [DW-1:0]     col_bp_seen [8];
   int                       idle_pct;
   int                       n_lookup;
   int                       n_load;
   int                       n_csr;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bilinear_table_lookup u_top (
      .clock, .reset, .start, .busy, .req_mode, .req_table_select, .req_row_index,
      .req_col_index, .req_load_value, .req_row_query, .req_col_query, .rsp_strobe,
      .rsp_interpolated, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   bltl_lookup_checker u_checker (
      .clock, .reset, .start, .busy, .req_mode, .req_table_select, .req_row_index,
      .req_col_index, .req_load_value, .req_row_query, .req_col_query, .rsp_strobe,
      .rsp_interpolated, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count,
      .pending
   );

   // safety limit
   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // present one word and hold it until accepted
   task automatic issue(input bltl_pkg::mode_type m, input logic [1:0] tsel,
                        input logic [3:0] ri, input logic [2:0] ci,
                        input logic signed [DW-1:0] val,
                        input logic signed [DW-1:0] rq, input logic signed [DW-1:0] cq);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= m;
      req_table_select <= tsel;
      req_row_index    <= ri;
      req_col_index    <= ci;
      req_load_value   <= val;
      req_row_query    <= rq;
      req_col_query    <= cq;
      do @(posedge clock); while (busy);
      if (m == bltl_pkg::MODE_LOOKUP) n_lookup++;
      else n_load++;
      if (m == bltl_pkg::MODE_ROW_BP) row_bp_seen[ri] = val;
      if (m == bltl_pkg::MODE_COL_BP) col_bp_seen[ci] = val;
   endtask

   // drain all results, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input bltl_pkg::csr_index_type idx,
                            input logic [bltl_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_csr++;
   endtask

   // ascending breakpoint sets, with tiny spans now and then and, with dup, one equal pair on each axis
   task automatic load_axes(input bit dup);
      logic signed [DW-1:0] v;
      int tiny;
      tiny = $urandom_range(3);
      v = DW'(-8388608 + int'($urandom_range(0, 1 << 22)));
      for (int i = 0; i < 16; i++) begin
         issue(bltl_pkg::MODE_ROW_BP, 2'($urandom), 4'(i), 3'($urandom), v, '0, '0);
         v += (dup && i == 4) ? DW'(0) : (tiny == 0) ? DW'($urandom_range(1, 4))
                                                      : DW'($urandom_range(1, 1 << 18));
      end
      v = DW'(-8388608 + int'($urandom_range(0, 1 << 22)));
      for (int i = 0; i < 8; i++) begin
         issue(bltl_pkg::MODE_COL_BP, 2'($urandom), 4'($urandom), 3'(i), v, '0, '0);
         v += (dup && i == 2) ? DW'(0) : (tiny == 1) ? DW'($urandom_range(1, 4))
                                                      : DW'($urandom_range(1, 1 << 19));
      end
   endtask

   function automatic logic signed [DW-1:0] aim(input logic signed [DW-1:0] b);
      if ($urandom_range(3) == 0) return DW'($urandom);
      return b + DW'($urandom_range(0, 1 << 17)) - DW'(1 << 16);
   endfunction

   initial begin
      logic [bltl_pkg::CSR_DATA_W-1:0] row_set [6];
      logic [bltl_pkg::CSR_DATA_W-1:0] col_set [6];
      int r;
      n_lookup = 0;
      n_load   = 0;
      n_csr    = 0;
      idle_pct = 0;
      row_set  = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd9, 5'd16};
      col_set  = '{5'd8, 5'd2, 5'd15, 5'd0, 5'd5, 5'd8};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry before any lookup
      load_axes(1'b0);
      for (int t = 0; t < NT; t++)
         for (int i = 0; i < 16; i++)
            for (int j = 0; j < 8; j++)
               issue(bltl_pkg::MODE_GRID, 2'(t), 4'(i), 3'(j),
                     (i + j == 0) ? DW'(-8388608) : (i + j == 22) ? DW'(8388607)
                                                 : DW'($urandom), '0, '0);
      wait_idle();
      write_csr(bltl_pkg::CSR_ROW_COUNT, 5'd16);
      write_csr(bltl_pkg::CSR_COL_COUNT, 5'd8);

      // directed: axis extremes, exact breakpoints, bad table, ignored write
      issue(bltl_pkg::MODE_LOOKUP, 2'd0, '0, '0, '0, DW'(-8388608), DW'(-8388608));
      issue(bltl_pkg::MODE_LOOKUP, 2'd1, '0, '0, '0, DW'(8388607), DW'(8388607));
      issue(bltl_pkg::MODE_LOOKUP, 2'd2, '0, '0, '0, row_bp_seen[0], col_bp_seen[7]);
      issue(bltl_pkg::MODE_LOOKUP, 2'd0, '0, '0, '0, row_bp_seen[5], col_bp_seen[3]);
      issue(bltl_pkg::MODE_LOOKUP, 2'd1, '0, '0, '0, row_bp_seen[15], col_bp_seen[0]);
      issue(bltl_pkg::MODE_LOOKUP, 2'd2, '0, '0, '0, DW'(row_bp_seen[7] + DW'(1)),
            DW'(col_bp_seen[6] - DW'(1)));
      issue(bltl_pkg::MODE_LOOKUP, 2'(NT), '0, '0, '0, '0, '0);
      issue(bltl_pkg::MODE_GRID, 2'(NT), 4'd15, 3'd7, DW'(8388607), '0, '0);
      issue(bltl_pkg::MODE_LOOKUP, 2'd0, '0, '0, '0, DW'(row_bp_seen[14] + DW'(7)),
            DW'(col_bp_seen[6] + DW'(3)));
      // equal neighbours, queried at and just below the repeated breakpoint
      load_axes(1'b1);
      issue(bltl_pkg::MODE_LOOKUP, 2'd0, '0, '0, '0, row_bp_seen[4], col_bp_seen[2]);
      issue(bltl_pkg::MODE_LOOKUP, 2'd1, '0, '0, '0, DW'(row_bp_seen[5] - DW'(1)),
            DW'(col_bp_seen[3] - DW'(1)));
      // descending pair
      issue(bltl_pkg::MODE_ROW_BP, 2'd0, 4'd3, '0, DW'(row_bp_seen[1] - DW'(100)), '0, '0);
      issue(bltl_pkg::MODE_LOOKUP, 2'd0, '0, '0, '0, DW'(row_bp_seen[2] - DW'(50)),
            col_bp_seen[1]);

      // random phases, each with its own counts
      for (int p = 0; p < 6; p++) begin
         idle_pct = (p < 2) ? 22 : (p < 4) ? 86 : 0;
         wait_idle();
         write_csr(bltl_pkg::CSR_ROW_COUNT, row_set[p]);
         write_csr(bltl_pkg::CSR_COL_COUNT, col_set[p]);
         for (int k = 0; k < 110; k++) begin
            if (k == 55) wait_idle();
            r = $urandom_range(99);
            if (r < 3) load_axes(1'($urandom_range(1)));
            else if (r < 6)
               issue(bltl_pkg::MODE_ROW_BP, 2'($urandom), 4'($urandom), 3'($urandom),
                     DW'($urandom), '0, '0);
            else if (r < 8)
               issue(bltl_pkg::MODE_COL_BP, 2'($urandom), 4'($urandom), 3'($urandom),
                     DW'($urandom), '0, '0);
            else if (r < 20)
               issue(bltl_pkg::MODE_GRID, 2'($urandom), 4'($urandom), 3'($urandom),
                     DW'($urandom), '0, '0);
            else
               issue(bltl_pkg::MODE_LOOKUP,
                     ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                     4'($urandom), 3'($urandom), DW'($urandom),
                     aim(row_bp_seen[$urandom_range(15)]), aim(col_bp_seen[$urandom_range(7)]));
         end
      end

      wait_idle();
      $display("covered %0d lookups, %0d load words, %0d register writes", n_lookup, n_load,
               n_csr);
      $display("counts swept from 2 up to 16 rows and 8 columns, out-of-range values too");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/bltl_pkg.sv
rtl/core/bltl_ram.sv
rtl/core/bltl_div.sv
rtl/core/bilinear_table_lookup.sv
test/bltl_lookup_checker.sv
test/tb_bilinear_table_lookup.sv
